FILE: src/qpq_pkg.sv
`default_nettype none
package qpq_pkg;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned Q_W     = 24;
	localparam int unsigned Q_FRAC  = 16;
	localparam int unsigned DIFF_W  = COORD_W + 1;
	localparam int unsigned PROD_W  = 2 * DIFF_W;
	localparam int unsigned DET_W   = PROD_W + 1;
	localparam int unsigned MAG_W   = DET_W + 1;
	localparam int unsigned SUM_W   = MAG_W + 1;
	localparam int unsigned QBITS   = Q_W + 1;
	localparam int unsigned REM_W   = MAG_W + Q_W + 1;
	localparam int unsigned LANES   = 4;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [Q_W-1:0] qval_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_SAT   = 2'd1,
		ST_DEGEN = 2'd2
	} status_t;
endpackage
`default_nettype wire

FILE: src/qpq_quad_if.sv
`default_nettype none
interface qpq_quad_if;
	import qpq_pkg::*;
	logic   valid;
	logic   ready;
	coord_t x_left_top;
	coord_t y_left_top;
	coord_t x_left_bottom;
	coord_t y_left_bottom;
	coord_t x_right_top;
	coord_t y_right_top;
	coord_t x_right_bottom;
	coord_t y_right_bottom;
	modport source (output valid, x_left_top, y_left_top, x_left_bottom, y_left_bottom,
		x_right_top, y_right_top, x_right_bottom, y_right_bottom, input ready);
	modport sink (input valid, x_left_top, y_left_top, x_left_bottom, y_left_bottom,
		x_right_top, y_right_top, x_right_bottom, y_right_bottom, output ready);
endinterface
`default_nettype wire

FILE: src/qpq_coef_if.sv
`default_nettype none
interface qpq_coef_if;
	import qpq_pkg::*;
	logic    valid;
	logic    ready;
	qval_t   q_left_top;
	qval_t   q_left_bottom;
	qval_t   q_right_top;
	qval_t   q_right_bottom;
	status_t result_status;
	modport source (output valid, q_left_top, q_left_bottom, q_right_top, q_right_bottom,
		result_status, input ready);
	modport sink (input valid, q_left_top, q_left_bottom, q_right_top, q_right_bottom,
		result_status, output ready);
endinterface
`default_nettype wire

FILE: src/quad_projective_q_coefficients.sv
// one quad per cycle unless the output stalls; 5 arithmetic stages then a 25-step
// restoring divider with one quotient bit per stage, four lanes side by side
// a stall on the output freezes the whole pipeline, nothing is lost or repeated
// reset (arst_n low, asynchronous) clears every valid bit; data registers are not reset
`default_nettype none
module quad_projective_q_coefficients (
	input  wire logic clk,
	input  wire logic arst_n,
	qpq_quad_if.sink  quad,
	qpq_coef_if.source coef
);
	import qpq_pkg::*;

	localparam int unsigned STEPS = QBITS;

	// global advance: the pipeline moves when the last stage is empty or drained
	logic adv;
	assign adv = !coef.valid || coef.ready;
	assign quad.ready = adv;

	// stage 1: corner differences
	logic                     vld_s1;
	logic signed [DIFF_W-1:0] dx14_s1, dy14_s1, dx23_s1, dy23_s1, dx12_s1, dy12_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= quad.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx14_s1 <= DIFF_W'(quad.x_left_top)    - DIFF_W'(quad.x_right_bottom);
			dy14_s1 <= DIFF_W'(quad.y_left_top)    - DIFF_W'(quad.y_right_bottom);
			dx23_s1 <= DIFF_W'(quad.x_left_bottom) - DIFF_W'(quad.x_right_top);
			dy23_s1 <= DIFF_W'(quad.y_left_bottom) - DIFF_W'(quad.y_right_top);
			dx12_s1 <= DIFF_W'(quad.x_left_top)    - DIFF_W'(quad.x_left_bottom);
			dy12_s1 <= DIFF_W'(quad.y_left_top)    - DIFF_W'(quad.y_left_bottom);
		end
	end

	// stage 2: the six cross products
	logic                     vld_s2;
	logic signed [PROD_W-1:0] pd0_s2, pd1_s2, pa0_s2, pa1_s2, pb0_s2, pb1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pd0_s2 <= PROD_W'(dx14_s1) * PROD_W'(dy23_s1);
			pd1_s2 <= PROD_W'(dy14_s1) * PROD_W'(dx23_s1);
			pa0_s2 <= PROD_W'(dx12_s1) * PROD_W'(dy23_s1);
			pa1_s2 <= PROD_W'(dy12_s1) * PROD_W'(dx23_s1);
			pb0_s2 <= PROD_W'(dy14_s1) * PROD_W'(dx12_s1);
			pb1_s2 <= PROD_W'(dx14_s1) * PROD_W'(dy12_s1);
		end
	end

	// stage 3: determinant d and the diagonal parameters a, b
	logic                    vld_s3;
	logic signed [DET_W-1:0] d_s3, a_s3, b_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s3 <= DET_W'(pd0_s2) - DET_W'(pd1_s2);
			a_s3 <= DET_W'(pa0_s2) - DET_W'(pa1_s2);
			b_s3 <= DET_W'(pb0_s2) - DET_W'(pb1_s2);
		end
	end

	// stage 4: distance ratios as magnitudes, degenerate check
	logic                    vld_s4, deg_s4;
	logic        [MAG_W-1:0] near1_s4, far1_s4, near2_s4, far2_s4;
	logic signed [MAG_W-1:0] dma, dmb;

	function automatic logic [MAG_W-1:0] abs_mag(input logic signed [MAG_W-1:0] v);
		abs_mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
	endfunction

	assign dma = MAG_W'(d_s3) - MAG_W'(a_s3);
	assign dmb = MAG_W'(d_s3) - MAG_W'(b_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s4   <= (d_s3 == '0) || (a_s3 == '0) || (a_s3 == d_s3) ||
				(b_s3 == '0) || (b_s3 == d_s3);
			near1_s4 <= abs_mag(MAG_W'(a_s3));
			far1_s4  <= abs_mag(dma);
			near2_s4 <= abs_mag(MAG_W'(b_s3));
			far2_s4  <= abs_mag(dmb);
		end
	end

	// stage 5 (divider slot 0): rounded numerators and divisors per lane
	// lanes: 0 left-top, 1 left-bottom, 2 right-top, 3 right-bottom
	logic             vld_s5 [STEPS+1];
	logic             deg_s5 [STEPS+1];
	logic [REM_W-1:0] rem_s5 [STEPS+1][LANES];
	logic [MAG_W-1:0] den_s5 [STEPS+1][LANES];
	logic [QBITS-1:0] quo_s5 [STEPS+1][LANES];

	logic [SUM_W-1:0] sum1, sum2;
	logic [MAG_W-1:0] den_in [LANES];
	logic [SUM_W-1:0] num_in [LANES];

	assign sum1 = SUM_W'(near1_s4) + SUM_W'(far1_s4);
	assign sum2 = SUM_W'(near2_s4) + SUM_W'(far2_s4);
	assign den_in[0] = far1_s4;
	assign den_in[1] = far2_s4;
	assign den_in[2] = near2_s4;
	assign den_in[3] = near1_s4;
	assign num_in[0] = sum1;
	assign num_in[1] = sum2;
	assign num_in[2] = sum2;
	assign num_in[3] = sum1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5[0] <= 1'b0;
		end else if (adv) begin
			vld_s5[0] <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			deg_s5[0] <= deg_s4;
			for (int l = 0; l < LANES; l++) begin
				rem_s5[0][l] <= (REM_W'(num_in[l]) << Q_FRAC) + REM_W'(den_in[l] >> 1);
				den_s5[0][l] <= den_in[l];
				quo_s5[0][l] <= '0;
			end
		end
	end

	// restoring divider, one quotient bit per stage, top bit flags overflow
	for (genvar j = 0; j < STEPS; j++) begin : g_div
		localparam int unsigned SH = STEPS - 1 - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s5[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s5[j+1] <= vld_s5[j];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [REM_W-1:0] shd;
			logic             ge;
			assign shd = REM_W'(den_s5[j][l]) << SH;
			assign ge  = rem_s5[j][l] >= shd;

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s5[j+1][l] <= ge ? (rem_s5[j][l] - shd) : rem_s5[j][l];
					den_s5[j+1][l] <= den_s5[j][l];
					quo_s5[j+1][l] <= {quo_s5[j][l][QBITS-2:0], ge};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				deg_s5[j+1] <= deg_s5[j];
			end
		end
	end

	// output: clamp, zero on degenerate, status
	qval_t q_out [LANES];
	logic  sat_any;

	always_comb begin
		sat_any = 1'b0;
		for (int l = 0; l < LANES; l++) begin
			sat_any = sat_any | quo_s5[STEPS][l][QBITS-1];
			if (deg_s5[STEPS]) begin
				q_out[l] = '0;
			end else if (quo_s5[STEPS][l][QBITS-1]) begin
				q_out[l] = '1;
			end else begin
				q_out[l] = quo_s5[STEPS][l][Q_W-1:0];
			end
		end
	end

	assign coef.valid          = vld_s5[STEPS];
	assign coef.q_left_top     = q_out[0];
	assign coef.q_left_bottom  = q_out[1];
	assign coef.q_right_top    = q_out[2];
	assign coef.q_right_bottom = q_out[3];
	assign coef.result_status  = deg_s5[STEPS] ? ST_DEGEN : (sat_any ? ST_SAT : ST_OK);

	// degenerate quads carry all-zero coefficients
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(coef.valid && coef.result_status == ST_DEGEN) |->
		(coef.q_left_top == '0 && coef.q_left_bottom == '0 &&
		coef.q_right_top == '0 && coef.q_right_bottom == '0))
		else $error("degenerate item with nonzero q");

	// a saturated item has at least one clamped coefficient
	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(coef.valid && coef.result_status == ST_SAT) |->
		(coef.q_left_top == '1 || coef.q_left_bottom == '1 ||
		coef.q_right_top == '1 || coef.q_right_bottom == '1))
		else $error("saturated status without clamped q");

	// a stalled output holds off new quads
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(coef.valid && !coef.ready) |-> !quad.ready)
		else $error("input accepted while output stalled");
endmodule
`default_nettype wire
